// ----- hdl/sti_pkg.sv -----
// Shared types and codes for the sorted table with insert and delete.
package sti_pkg;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } t_req;

    localparam int unsigned OUT_COUNT_W = 5;

endpackage

// ----- hdl/sorted_table_insert_delete.sv -----
// Sorted table of signed words with insert and delete, one shared compare unit.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+------------------------------------------
//  request | i_valid  | o_stall  | i_req_type, i_value
//  result  | o_valid  | i_stall  | o_status, o_entry_count, o_empty_res
//
//  An insert walks down from the top entry, moving each entry >= the value up
//  one place, then writes the value in S_PUT. A delete scans all stored
//  entries and closes the gap as it goes. A full insert or an empty delete
//  goes straight to S_FIN. The table memory has a registered read, so each
//  entry takes a read step (S_RD) and a compare step (S_CMP). i_rst_n clears
//  the count and the control state; table contents are not cleared. A stalled
//  result holds the block after finishing until the word is taken.
module sorted_table_insert_delete
    import sti_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [0:0]             i_req_type,
    input  logic signed [31:0]     i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [OUT_COUNT_W-1:0] o_entry_count,
    output logic [0:0]             o_empty_res
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_PUT  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    logic signed [31:0] r_mem [CAPACITY];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_req, n_req;
    logic signed [31:0] r_value, n_value;
    logic               r_found, n_found;
    t_status            r_res, n_res;
    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_ostatus, n_ostatus;
    logic [CW-1:0]      r_ocount, n_ocount;
    logic signed [31:0] r_rd_data;

    logic               w_en;
    logic [AW-1:0]      w_addr;
    logic signed [31:0] w_data;
    logic [AW-1:0]      rd_addr;
    logic               cmp_lt, cmp_eq;
    logic [CW:0]        idx_p1;
    logic               last_idx;
    logic [CW+OUT_COUNT_W-1:0] count_ext;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign rd_addr  = (r_req == REQ_INSERT) ? r_idx - AW'(1) : r_idx;
    assign cmp_lt   = r_rd_data < r_value;
    assign cmp_eq   = r_rd_data == r_value;
    assign idx_p1   = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign last_idx = idx_p1 == {1'b0, r_count};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_req     = r_req;
        n_value   = r_value;
        n_found   = r_found;
        n_res     = r_res;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_ocount  = r_ocount;
        w_en      = 1'b0;
        w_addr    = r_idx;
        w_data    = r_value;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req_type[0];
                    n_value = i_value;
                    n_found = 1'b0;
                    if (i_req_type[0] == REQ_INSERT) begin
                        n_idx = AW'(r_count);
                        if (r_count == CW'(CAPACITY)) begin
                            n_res   = ST_FULL;
                            n_state = S_FIN;
                        end else if (r_count == '0) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_res   = ST_NOT_FOUND;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_req == REQ_INSERT) begin
                    if (!cmp_lt) begin
                        w_en   = 1'b1;
                        w_addr = r_idx;
                        w_data = r_rd_data;
                        n_idx  = r_idx - AW'(1);
                        n_state = (r_idx == AW'(1)) ? S_PUT : S_RD;
                    end else begin
                        n_state = S_PUT;
                    end
                end else begin
                    if (r_found) begin
                        w_en   = 1'b1;
                        w_addr = r_idx - AW'(1);
                        w_data = r_rd_data;
                    end else if (cmp_eq) begin
                        n_found = 1'b1;
                    end
                    if (last_idx) begin
                        if (r_found || cmp_eq) begin
                            n_count = r_count - CW'(1);
                            n_res   = ST_DELETED;
                        end else begin
                            n_res   = ST_NOT_FOUND;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_PUT: begin
                w_en    = 1'b1;
                w_addr  = r_idx;
                w_data  = r_value;
                n_count = r_count + CW'(1);
                n_res   = ST_INSERTED;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res;
                    n_ocount  = r_count;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
        r_idx     <= n_idx;
        r_req     <= n_req;
        r_value   <= n_value;
        r_res     <= n_res;
        r_ostatus <= n_ostatus;
        r_ocount  <= n_ocount;
    end

    assign count_ext     = {{OUT_COUNT_W{1'b0}}, r_ocount};
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_entry_count = count_ext[OUT_COUNT_W-1:0];
    assign o_empty_res   = (r_ocount == '0);

endmodule

// ----- dv/tb_top.sv -----
// Sorted table tb: directed table then random requests, checked vs typed replies or a predictor.
`timescale 1ns / 1ps

module tb_top;
    import sti_pkg::*;

    localparam int TBL_CAP    = 16;
    localparam int N_ITEMS    = 1450;
    localparam int QUIET_TAIL = 150;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 300;
    localparam int DRAIN_AT   = 700;

    typedef struct packed {
        t_status        status;
        logic [4:0]     count;
        logic           empty;
    } table_reply_t;

    typedef struct packed {
        t_req               req;
        logic signed [31:0] value;
        logic               typed;
        table_reply_t       reply;
    } dir_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [0:0]             i_req_type = 1'b0;
    logic signed [31:0]     i_value = 32'sd0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [1:0]             o_status;
    logic [OUT_COUNT_W-1:0] o_entry_count;
    logic [0:0]             o_empty_res;

    logic signed [31:0] tbl_vals [TBL_CAP];
    int                 tbl_count = 0;
    table_reply_t       reply_q [$];
    int                 n_err = 0;

    bit quiet_tail = 1'b0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int burst_left = 0;

    dir_row_t dir_rows [25] = '{
        '{REQ_DELETE, 32'sd0,          1'b1, '{ST_NOT_FOUND, 5'd0,  1'b1}},
        '{REQ_INSERT, 32'sh80000000,   1'b1, '{ST_INSERTED,  5'd1,  1'b0}},
        '{REQ_INSERT, 32'sh7fffffff,   1'b1, '{ST_INSERTED,  5'd2,  1'b0}},
        '{REQ_DELETE, 32'sh80000000,   1'b1, '{ST_DELETED,   5'd1,  1'b0}},
        '{REQ_DELETE, 32'sh7fffffff,   1'b1, '{ST_DELETED,   5'd0,  1'b1}},
        '{REQ_INSERT, 32'sd0,          1'b1, '{ST_INSERTED,  5'd1,  1'b0}},
        '{REQ_INSERT, -32'sd1,         1'b1, '{ST_INSERTED,  5'd2,  1'b0}},
        '{REQ_INSERT, 32'sd1,          1'b1, '{ST_INSERTED,  5'd3,  1'b0}},
        '{REQ_INSERT, 32'sd100,        1'b1, '{ST_INSERTED,  5'd4,  1'b0}},
        '{REQ_INSERT, -32'sd100,       1'b1, '{ST_INSERTED,  5'd5,  1'b0}},
        '{REQ_INSERT, 32'sd100,        1'b1, '{ST_INSERTED,  5'd6,  1'b0}},
        '{REQ_INSERT, 32'sd7,          1'b1, '{ST_INSERTED,  5'd7,  1'b0}},
        '{REQ_INSERT, -32'sd7,         1'b1, '{ST_INSERTED,  5'd8,  1'b0}},
        '{REQ_INSERT, -32'sd7,         1'b1, '{ST_INSERTED,  5'd9,  1'b0}},
        '{REQ_INSERT, 32'sh7fffffff,   1'b1, '{ST_INSERTED,  5'd10, 1'b0}},
        '{REQ_INSERT, 32'sh80000000,   1'b1, '{ST_INSERTED,  5'd11, 1'b0}},
        '{REQ_INSERT, 32'sd3,          1'b1, '{ST_INSERTED,  5'd12, 1'b0}},
        '{REQ_INSERT, 32'sd2,          1'b1, '{ST_INSERTED,  5'd13, 1'b0}},
        '{REQ_INSERT, 32'sd1,          1'b1, '{ST_INSERTED,  5'd14, 1'b0}},
        '{REQ_INSERT, 32'sd50,         1'b1, '{ST_INSERTED,  5'd15, 1'b0}},
        '{REQ_INSERT, 32'sd49,         1'b1, '{ST_INSERTED,  5'd16, 1'b0}},
        '{REQ_INSERT, 32'sd5,          1'b1, '{ST_FULL,      5'd16, 1'b0}},
        '{REQ_DELETE, -32'sd7,         1'b0, '{ST_INSERTED,  5'd0,  1'b0}},
        '{REQ_DELETE, 32'sd12345,      1'b1, '{ST_NOT_FOUND, 5'd15, 1'b0}},
        '{REQ_INSERT, 32'sh80000000,   1'b0, '{ST_INSERTED,  5'd0,  1'b0}}
    };

    sorted_table_insert_delete #(
        .CAPACITY(TBL_CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_empty_res   (o_empty_res)
    );

    always #5 i_clk = ~i_clk;

    function automatic table_reply_t apply_request(t_req req, logic signed [31:0] val);
        table_reply_t r;
        int pos;
        int k;
        r = '0;
        if (req == REQ_INSERT) begin
            if (tbl_count >= TBL_CAP) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < tbl_count && tbl_vals[pos] < val) pos++;
                for (k = tbl_count; k > pos; k--) tbl_vals[k] = tbl_vals[k-1];
                tbl_vals[pos] = val;
                tbl_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            r.status = ST_NOT_FOUND;
            pos = -1;
            for (k = 0; k < tbl_count; k++) begin
                if (pos < 0 && tbl_vals[k] == val) pos = k;
            end
            if (pos >= 0) begin
                for (k = pos; k + 1 < tbl_count; k++) tbl_vals[k] = tbl_vals[k+1];
                tbl_count--;
                r.status = ST_DELETED;
            end
        end
        r.count = 5'(tbl_count);
        r.empty = (tbl_count == 0);
        return r;
    endfunction

    task automatic offer_word(t_req req, logic signed [31:0] val, logic typed,
                              table_reply_t typed_reply);
        table_reply_t pred;
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        pred = apply_request(req, val);
        reply_q.push_back(typed ? typed_reply : pred);
    endtask

    task automatic idle_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            return 32'($signed($urandom_range(0, 8)) - 4);
        end else if (mode < 6) begin
            case ($urandom_range(0, 5))
                0: return 32'sh80000000;
                1: return 32'sh80000001;
                2: return 32'sh7fffffff;
                3: return 32'sh7ffffffe;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    // result side: random stall bursts, one long hold on request, none in the tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN - 1;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (quiet_tail) begin
            burst_left <= 0;
            i_stall    <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(1, 18) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        table_reply_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d count=%0d empty=%0d",
                         $time, o_status, o_entry_count, o_empty_res);
                n_err++;
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    n_err++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    n_err++;
                end
                if (o_empty_res !== want.empty) begin
                    $display("%0t: empty_res expected %0d actual %0d",
                             $time, want.empty, o_empty_res);
                    n_err++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        int sent;
        int seg_left;
        int ins_pct;
        bit seg_idle;
        t_req req;
        logic signed [31:0] val;
        int guard;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            offer_word(dir_rows[r].req, dir_rows[r].value, dir_rows[r].typed,
                       dir_rows[r].reply);
            if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 18));
        end

        sent = $size(dir_rows);
        seg_left = 0;
        ins_pct = 50;
        seg_idle = 1'b1;
        while (sent < N_ITEMS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: ins_pct = 85;
                    1: ins_pct = 15;
                    default: ins_pct = 50;
                endcase
                seg_idle = ($urandom_range(0, 3) != 0);
            end
            seg_left--;
            if (sent == N_ITEMS - QUIET_TAIL) quiet_tail <= 1'b1;
            if (sent == HOLD_AT) hold_seq <= hold_seq + 1;
            if (sent == DRAIN_AT) begin
                i_valid <= 1'b0;
                while (reply_q.size() != 0) @(posedge i_clk);
            end

            req = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
            if (req == REQ_DELETE && tbl_count > 0 && $urandom_range(0, 9) < 6)
                val = tbl_vals[$urandom_range(0, tbl_count - 1)];
            else
                val = pick_value();
            offer_word(req, val, 1'b0, '0);
            sent++;

            if (seg_idle && sent < N_ITEMS - QUIET_TAIL
                    && !(sent > HOLD_AT && sent < HOLD_AT + 30)
                    && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 18));
        end
        i_valid <= 1'b0;

        guard = 0;
        while (reply_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (reply_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, reply_q.size());
            n_err += reply_q.size();
        end
        repeat (40) @(posedge i_clk);

        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- sorted_table_insert_delete.f -----
hdl/sti_pkg.sv
hdl/sorted_table_insert_delete.sv
dv/tb_top.sv
